// ===== hdl/assert_macros.svh =====
// Assertion helpers for the keyer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MCK_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define MCK_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/mck_pkg.sv =====
`default_nettype none

package mck_pkg;

	localparam int CHAR_W    = 8;
	localparam int KIND_W    = 2;
	localparam int UNIT_W    = 16;
	localparam int DUR_W     = 19;
	localparam int UNITS_W   = 3;
	localparam int PAT_W     = 5;
	localparam int CNT_W     = 3;
	localparam int STEP_W    = 3;

	localparam logic [UNIT_W-1:0] UNIT_RESET = 16'd1000;

	localparam logic [UNITS_W-1:0] DOT_UNITS    = 3'd1;
	localparam logic [UNITS_W-1:0] DASH_UNITS   = 3'd3;
	localparam logic [UNITS_W-1:0] ELEM_GAP     = 3'd1;
	localparam logic [UNITS_W-1:0] CHAR_SPACE   = 3'd3;
	localparam logic [UNITS_W-1:0] WORD_SPACE   = 3'd7;

	localparam logic [KIND_W-1:0] KIND_ELEM   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LETTER = 2'd1;

	// Microprogram step addresses
	localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
	localparam logic [STEP_W-1:0] STEP_TEST  = 3'd1;
	localparam logic [STEP_W-1:0] STEP_MARK  = 3'd2;
	localparam logic [STEP_W-1:0] STEP_GAP   = 3'd3;
	localparam logic [STEP_W-1:0] STEP_TRAIL = 3'd4;

	// Jump conditions
	localparam logic [1:0] COND_ALWAYS = 2'd0;
	localparam logic [1:0] COND_START  = 2'd1;
	localparam logic [1:0] COND_EMPTY  = 2'd2;
	localparam logic [1:0] COND_FINAL  = 2'd3;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic [KIND_W-1:0] kind;
	} in_t;

	typedef struct packed {
		logic              key_on;
		logic [DUR_W-1:0]  duration;
		logic              last;
		logic              unsupported;
	} out_t;

	// One control word of the microprogram
	typedef struct packed {
		logic              emit;
		logic              mark;
		logic              use_trail;
		logic              consume;
		logic [1:0]        cond;
		logic [STEP_W-1:0] jump;
		logic [STEP_W-1:0] next;
	} ctrl_t;

	// Datapath status seen by the sequencer
	typedef struct packed {
		logic empty;
		logic final_elem;
	} stat_t;

	typedef struct packed {
		logic             unsup;
		logic [CNT_W-1:0] len;
		logic [PAT_W-1:0] pat;
	} code_t;

	// {len, pattern}; pattern is LSB first, 1 = dash
	localparam logic [CNT_W+PAT_W-1:0] LETTER_TAB [26] = '{
		{3'd2, 5'b00010}, {3'd4, 5'b00001}, {3'd4, 5'b00101}, {3'd3, 5'b00001},
		{3'd1, 5'b00000}, {3'd4, 5'b00100}, {3'd3, 5'b00011}, {3'd4, 5'b00000},
		{3'd2, 5'b00000}, {3'd4, 5'b01110}, {3'd3, 5'b00101}, {3'd4, 5'b00010},
		{3'd2, 5'b00011}, {3'd2, 5'b00001}, {3'd3, 5'b00111}, {3'd4, 5'b00110},
		{3'd4, 5'b01011}, {3'd3, 5'b00010}, {3'd3, 5'b00000}, {3'd1, 5'b00001},
		{3'd3, 5'b00100}, {3'd4, 5'b01000}, {3'd3, 5'b00110}, {3'd4, 5'b01001},
		{3'd4, 5'b01101}, {3'd4, 5'b00011}
	};

	localparam logic [PAT_W-1:0] DIGIT_TAB [10] = '{
		5'b11111, 5'b11110, 5'b11100, 5'b11000, 5'b10000,
		5'b00000, 5'b00001, 5'b00011, 5'b00111, 5'b01111
	};

	function automatic code_t lookup_code(input logic [CHAR_W-1:0] ch);
		code_t            c;
		logic [CHAR_W-1:0] up;
		logic [CHAR_W-1:0] off;
		up  = ch;
		off = '0;
		c   = '{unsup: 1'b1, len: '0, pat: '0};
		if (ch inside {[8'h61:8'h7a]})
			up = ch - 8'h20;
		if (up inside {[8'h41:8'h5a]}) begin
			off   = up - 8'h41;
			c.unsup = 1'b0;
			{c.len, c.pat} = LETTER_TAB[off[4:0]];
		end else if (up inside {[8'h30:8'h39]}) begin
			off   = up - 8'h30;
			c.unsup = 1'b0;
			c.len = 3'd5;
			c.pat = DIGIT_TAB[off[3:0]];
		end
		return c;
	endfunction

	function automatic logic [UNITS_W-1:0] trail_units(input logic [KIND_W-1:0] kind);
		case (kind)
			KIND_ELEM:   return ELEM_GAP;
			KIND_LETTER: return CHAR_SPACE;
			default:     return WORD_SPACE;
		endcase
	endfunction

endpackage

`default_nettype wire

// ===== hdl/mck_seq.sv =====
`default_nettype none

module mck_seq import mck_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	input  wire stat_t stat,
	output logic       busy,
	output logic       load,
	output ctrl_t      ctrl
);

	logic [STEP_W-1:0] step_q;
	logic              take;

	// Control store
	always_comb begin
		ctrl = '{emit: 1'b0, mark: 1'b0, use_trail: 1'b0, consume: 1'b0,
			cond: COND_ALWAYS, jump: STEP_IDLE, next: STEP_IDLE};
		case (step_q)
			STEP_IDLE: begin
				ctrl.cond = COND_START;
				ctrl.jump = STEP_TEST;
				ctrl.next = STEP_IDLE;
			end
			STEP_TEST: begin
				ctrl.cond = COND_EMPTY;
				ctrl.jump = STEP_TRAIL;
				ctrl.next = STEP_MARK;
			end
			STEP_MARK: begin
				ctrl.emit    = 1'b1;
				ctrl.mark    = 1'b1;
				ctrl.consume = 1'b1;
				ctrl.cond    = COND_FINAL;
				ctrl.jump    = STEP_TRAIL;
				ctrl.next    = STEP_GAP;
			end
			STEP_GAP: begin
				ctrl.emit = 1'b1;
				ctrl.jump = STEP_MARK;
			end
			STEP_TRAIL: begin
				ctrl.emit      = 1'b1;
				ctrl.use_trail = 1'b1;
				ctrl.jump      = STEP_IDLE;
			end
			default: begin
				ctrl.jump = STEP_IDLE;
			end
		endcase
	end

	always_comb begin
		case (ctrl.cond)
			COND_START: take = start;
			COND_EMPTY: take = stat.empty;
			COND_FINAL: take = stat.final_elem;
			default:    take = 1'b1;
		endcase
	end

	assign busy = (step_q != STEP_IDLE);
	assign load = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= take ? ctrl.jump : ctrl.next;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/mck_dp.sv =====
`default_nettype none

module mck_dp import mck_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire in_t                cmd,
	input  wire ctrl_t              ctrl,
	input  wire logic               cfg_we,
	input  wire logic [UNIT_W-1:0]  cfg_wdata,
	output stat_t                   stat,
	output logic                    strobe,
	output out_t                    result
);

	logic [UNIT_W-1:0]  unit_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [PAT_W-1:0]   pat_q;
	logic [UNITS_W-1:0] trail_q;
	logic               unsup_q;
	logic               strobe_q;
	out_t               result_q;
	code_t              code;
	logic [UNITS_W-1:0] units;
	logic [DUR_W-1:0]   dur;

	assign code = lookup_code(cmd.char_code);

	assign stat = '{empty: (cnt_q == '0), final_elem: (cnt_q == CNT_W'(1))};

	always_comb begin
		if (ctrl.use_trail)
			units = trail_q;
		else if (ctrl.mark)
			units = pat_q[0] ? DASH_UNITS : DOT_UNITS;
		else
			units = ELEM_GAP;
	end

	assign dur = DUR_W'(units) * DUR_W'(unit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q   <= UNIT_RESET;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			if (cfg_we)
				unit_q <= cfg_wdata;
			if (load)
				cnt_q <= code.len;
			else if (ctrl.consume)
				cnt_q <= cnt_q - CNT_W'(1);
			strobe_q <= ctrl.emit;
		end
	end

	// Character payload: hold from accept, shift one element per mark
	always_ff @(posedge clk) begin
		if (load) begin
			pat_q   <= code.pat;
			trail_q <= trail_units(cmd.kind);
			unsup_q <= code.unsup;
		end else if (ctrl.consume) begin
			pat_q <= pat_q >> 1;
		end
		if (ctrl.emit) begin
			result_q.key_on      <= ctrl.mark;
			result_q.duration    <= dur;
			result_q.last        <= ctrl.use_trail;
			result_q.unsupported <= ctrl.use_trail && unsup_q;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

`default_nettype wire

// ===== hdl/morse_code_keyer_top.sv =====
// Morse keyer: one character in, up to ten keying segments out, one per cycle.
// Once a character is accepted the sequencer passes its test step and the first
// mark step emits; each segment is registered onto the result ports. Segments
// come one per microprogram step after the test step; a new character is taken
// only from the idle step. The receiver cannot stall; results are strobed.
// Reset (async, active low): sequencer to idle, strobe low, unit_ticks = 1000.
`default_nettype none

module morse_code_keyer_top import mck_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire in_t               cmd,
	input  wire logic              cfg_we,
	input  wire logic [UNIT_W-1:0] cfg_wdata,
	output logic                   strobe,
	output out_t                   result
);

`include "assert_macros.svh"

	ctrl_t ctrl;
	stat_t stat;
	logic  load;

	// Sequencer: step counter walking the control store; it accepts an item
	// only from its idle step and jumps on start, empty code, or final element.
	mck_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.load   (load),
		.ctrl   (ctrl)
	);

	// Datapath: element counter, dash/dot shift register, trailer units,
	// unit_ticks register, small unit multiplier and the registered result.
	mck_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.cmd       (cmd),
		.ctrl      (ctrl),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.stat      (stat),
		.strobe    (strobe),
		.result    (result)
	);

	// Only the trailing gap may appear after the sequencer has gone idle
	`MCK_ASSERT_NOW(a_idle_last, strobe && !busy, result.last, "non-final segment while idle")
	// The unsupported flag rides only on a trailing space
	`MCK_ASSERT_NOW(a_unsup_gap, strobe && result.unsupported, result.last && !result.key_on,
		"unsupported flag off the trailing gap")
	// A mark is always followed at once by a space
	`MCK_ASSERT_NEXT(a_mark_space, strobe && result.key_on, strobe && !result.key_on,
		"mark not followed by a space")
	// Accepting an item leaves the block busy
	`MCK_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accept without going busy")

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
	import mck_pkg::*;

	// Trailer kinds that the package does not name
	localparam logic [KIND_W-1:0] KIND_WORD  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

	// Cycles with no item, no segment and no register write before the run is abandoned
	localparam int IDLE_LIMIT = 300;
	localparam int RAND_PHASES = 5;
	localparam int PHASE_CHARS = 18;
	localparam int DIR_ROWS = 23;

	// One directed row: a character and a trailer kind. Rows for codes with no Morse
	// pattern carry their single trailing space, read straight off the 1000-tick unit.
	typedef struct packed {
		in_t              item;
		logic             typed;
		logic [DUR_W-1:0] trail_dur;
	} dir_row_t;

	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{'{8'h00, KIND_ELEM},   1'b1, 19'd1000},
		'{'{8'hFF, KIND_SPARE},  1'b1, 19'd7000},
		'{'{8'h80, KIND_LETTER}, 1'b1, 19'd3000},
		'{'{8'h7F, KIND_WORD},   1'b1, 19'd7000},
		'{'{8'h40, KIND_LETTER}, 1'b1, 19'd3000},
		'{'{"A",   KIND_ELEM},   1'b0, 19'd0},
		'{'{"Z",   KIND_LETTER}, 1'b0, 19'd0},
		'{'{8'h5B, KIND_WORD},   1'b1, 19'd7000},
		'{'{8'h60, KIND_SPARE},  1'b1, 19'd7000},
		'{'{"a",   KIND_LETTER}, 1'b0, 19'd0},
		'{'{"z",   KIND_WORD},   1'b0, 19'd0},
		'{'{8'h7B, KIND_ELEM},   1'b1, 19'd1000},
		'{'{8'h2F, KIND_LETTER}, 1'b1, 19'd3000},
		'{'{"0",   KIND_WORD},   1'b0, 19'd0},
		'{'{"9",   KIND_SPARE},  1'b0, 19'd0},
		'{'{8'h3A, KIND_ELEM},   1'b1, 19'd1000},
		'{'{"K",   KIND_LETTER}, 1'b0, 19'd0},
		'{'{"k",   KIND_WORD},   1'b0, 19'd0},
		'{'{"C",   KIND_LETTER}, 1'b0, 19'd0},
		'{'{"E",   KIND_ELEM},   1'b0, 19'd0},
		'{'{"T",   KIND_SPARE},  1'b0, 19'd0},
		'{'{"5",   KIND_LETTER}, 1'b0, 19'd0},
		'{'{"Q",   KIND_WORD},   1'b0, 19'd0}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	in_t               cmd = '0;
	logic              cfg_we = 1'b0;
	logic [UNIT_W-1:0] cfg_wdata = '0;
	logic              strobe;
	out_t              result;

	// Model copy of the unit register, and the segments still owed by the keyer
	logic [UNIT_W-1:0] unit_ticks_model = UNIT_RESET;
	out_t              segs_due [$];
	out_t              seg_want;

	int unsigned chars_sent = 0;
	int unsigned segs_checked = 0;
	int unsigned unit_settings = 1;
	int unsigned errors = 0;
	int unsigned idle_cycles = 0;

	morse_code_keyer_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.strobe    (strobe),
		.result    (result)
	);

	always #2 clk = ~clk;

	// Dot/dash pattern of a character after folding lower case; empty when it has none
	function automatic string morse_pattern(input logic [CHAR_W-1:0] ch);
		logic [CHAR_W-1:0] up;
		up = (ch >= "a" && ch <= "z") ? ch - 8'h20 : ch;
		case (up)
			"A": return ".-";    "B": return "-...";  "C": return "-.-.";
			"D": return "-..";   "E": return ".";     "F": return "..-.";
			"G": return "--.";   "H": return "....";  "I": return "..";
			"J": return ".---";  "K": return "-.-";   "L": return ".-..";
			"M": return "--";    "N": return "-.";    "O": return "---";
			"P": return ".--.";  "Q": return "--.-";  "R": return ".-.";
			"S": return "...";   "T": return "-";     "U": return "..-";
			"V": return "...-";  "W": return ".--";   "X": return "-..-";
			"Y": return "-.--";  "Z": return "--..";
			"0": return "-----"; "1": return ".----"; "2": return "..---";
			"3": return "...--"; "4": return "....-"; "5": return ".....";
			"6": return "-...."; "7": return "--..."; "8": return "---..";
			"9": return "----.";
			default: return "";
		endcase
	endfunction

	function automatic void add_segment(input logic on, input logic [UNITS_W-1:0] units,
			input logic is_last, input logic unsup);
		logic [31:0] ticks;
		out_t        seg;
		ticks = units * unit_ticks_model;
		seg.key_on      = on;
		seg.duration    = ticks[DUR_W-1:0];
		seg.last        = is_last;
		seg.unsupported = unsup;
		segs_due.push_back(seg);
	endfunction

	// Queue every segment one character produces under the current unit length
	function automatic void predict_segments(input in_t c);
		string               pat;
		logic [UNITS_W-1:0]  trail;
		pat = morse_pattern(c.char_code);
		if (c.kind == KIND_ELEM)
			trail = ELEM_GAP;
		else if (c.kind == KIND_LETTER)
			trail = CHAR_SPACE;
		else
			trail = WORD_SPACE;
		// no pattern: only the trailing space, flagged
		if (pat.len() == 0) begin
			add_segment(1'b0, trail, 1'b1, 1'b1);
			return;
		end
		for (int i = 0; i < pat.len(); i++) begin
			if (i > 0)
				add_segment(1'b0, ELEM_GAP, 1'b0, 1'b0);
			add_segment(1'b1, (pat[i] == "-") ? DASH_UNITS : DOT_UNITS, 1'b0, 1'b0);
		end
		add_segment(1'b0, trail, 1'b1, 1'b0);
	endfunction

	// Offer one character after a gap; return at the edge that accepts it.
	// With no gap, start stays high from the previous item and only cmd moves.
	task automatic send_char(input in_t c, input int unsigned gap, input logic typed,
			input logic [DUR_W-1:0] trail_dur);
		out_t seg;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do
			@(posedge clk);
		while (busy);
		if (typed) begin
			seg = '{key_on: 1'b0, duration: trail_dur, last: 1'b1, unsupported: 1'b1};
			segs_due.push_back(seg);
		end else begin
			predict_segments(c);
		end
		chars_sent++;
	endtask

	// Drop start, drain all owed segments, let the sequencer settle, then write the unit
	task automatic set_unit_ticks(input logic [UNIT_W-1:0] value);
		start <= 1'b0;
		while (segs_due.size() != 0)
			@(posedge clk);
		while (busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		unit_ticks_model = value;
		unit_settings++;
	endtask

	// Random character: mostly letters of either case and digits, now and then any code
	function automatic in_t random_char();
		in_t c;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: c.char_code = CHAR_W'("A" + $urandom_range(0, 25));
			4, 5:       c.char_code = CHAR_W'("a" + $urandom_range(0, 25));
			6, 7:       c.char_code = CHAR_W'("0" + $urandom_range(0, 9));
			default:    c.char_code = CHAR_W'($urandom_range(0, 255));
		endcase
		c.kind = KIND_W'($urandom_range(0, 3));
		return c;
	endfunction

	// Check every strobed segment against the oldest one owed
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (segs_due.size() == 0) begin
				$display("%0t: unexpected segment %p", $time, result);
				errors++;
			end else begin
				seg_want = segs_due.pop_front();
				if (result.key_on !== seg_want.key_on) begin
					$display("%0t: key_on expected %0b actual %0b",
						$time, seg_want.key_on, result.key_on);
					errors++;
				end
				if (result.duration !== seg_want.duration) begin
					$display("%0t: duration expected %0d actual %0d",
						$time, seg_want.duration, result.duration);
					errors++;
				end
				if (result.last !== seg_want.last) begin
					$display("%0t: last expected %0b actual %0b",
						$time, seg_want.last, result.last);
					errors++;
				end
				if (result.unsupported !== seg_want.unsupported) begin
					$display("%0t: unsupported expected %0b actual %0b",
						$time, seg_want.unsupported, result.unsupported);
					errors++;
				end
				segs_checked++;
			end
		end
	end

	// Watchdog: any item, segment or register write counts as progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || strobe || cfg_we)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no progress for %0d cycles, %0d segments still owed",
					$time, idle_cycles, segs_due.size());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		logic [UNIT_W-1:0] phase_units [RAND_PHASES];
		int unsigned       gap;

		// Hold reset low, then release it on a rising edge
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows at the reset unit length
		for (int r = 0; r < DIR_ROWS; r++)
			send_char(DIRECTED[r].item, $urandom_range(0, 12), DIRECTED[r].typed,
				DIRECTED[r].trail_dur);

		// Unit extremes, zero length, then two arbitrary values
		phase_units[0] = 16'd1;
		phase_units[1] = 16'hFFFF;
		phase_units[2] = 16'd0;
		phase_units[3] = UNIT_W'($urandom_range(0, 65535));
		phase_units[4] = UNIT_W'($urandom_range(0, 65535));

		for (int p = 0; p < RAND_PHASES; p++) begin
			set_unit_ticks(phase_units[p]);
			for (int n = 0; n < PHASE_CHARS; n++) begin
				// the first third of each phase runs back to back
				gap = (n < PHASE_CHARS / 3) ? 0 : $urandom_range(0, 12);
				send_char(random_char(), gap, 1'b0, '0);
			end
		end

		// Drain, then give the keyer time to show any stray segment
		start <= 1'b0;
		while (segs_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Keyed %0d characters (%0d directed) across %0d unit lengths,",
			chars_sent, DIR_ROWS, unit_settings);
		$display("checked %0d segments, %0d mismatches.", segs_checked, errors);
		if (errors == 0 && segs_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
